/* sv/bmsp_pkg.sv */
`timescale 1ns / 1ps
package bmsp_pkg;
  localparam int PRIME_DEFAULT = 10007;
  localparam int RES_W = 14;
  localparam int QUEUE_DEPTH = 4;

  // item handed from front to back
  typedef struct packed {
    logic        zero;
    logic [30:0] n;
    logic [30:0] k;
    logic [30:0] d;
  } bmsp_item_t;
endpackage

/* sv/bmsp_front.sv */
`timescale 1ns / 1ps
module bmsp_front (
  input  logic clk,
  input  logic rst,
  input  logic signed [31:0] n_value,
  input  logic signed [31:0] k_value,
  input  logic push,
  output logic full,
  output bmsp_pkg::bmsp_item_t item,
  output logic item_valid,
  input  logic item_take
);
  import bmsp_pkg::*;
  localparam int QDEPTH = QUEUE_DEPTH;
  localparam int AW = $clog2(QDEPTH);

  bmsp_item_t mem [QDEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  bmsp_item_t cls;
  logic [32:0] diff;
  logic do_push, do_pop;

  // classify: negative argument or k above n gives zero
  always_comb begin
    diff = {n_value[31], n_value} - {k_value[31], k_value};
    cls.zero = n_value[31] | k_value[31] | diff[32];
    cls.n = n_value[30:0];
    cls.k = k_value[30:0];
    cls.d = diff[30:0];
  end

  assign full = (count == (AW+1)'(QDEPTH));
  assign item_valid = (count != '0);
  assign do_push = push & ~full;
  assign do_pop = item_take & item_valid;
  assign item = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == AW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(QDEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |=> count == $past(count) - (AW+1)'($past(do_pop))) else $error("push while full");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_pop) else $error("pop from empty queue");
endmodule

/* sv/bmsp_back.sv */
`timescale 1ns / 1ps
module bmsp_back #(
  parameter int PRIME = bmsp_pkg::PRIME_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  bmsp_pkg::bmsp_item_t item,
  input  logic item_valid,
  output logic item_take,
  output logic [13:0] binom_residue,
  output logic empty,
  input  logic pop
);
  import bmsp_pkg::*;
  localparam int TW = $clog2(PRIME);
  localparam int RW = 31;
  localparam int EBW = $clog2(TW+1);
  // reciprocal of the prime for quotients of values below 2^31
  localparam int S2 = 30 + TW;
  localparam logic [RW-1:0] BAR_M = RW'((64'd1 << S2) / PRIME);
  localparam logic [TW-1:0] ONE = TW'(1 % PRIME);
  localparam logic signed [TW+1:0] PS = (TW+2)'(PRIME);

  localparam logic [4:0] S_FILL = 5'd0, S_FILLN = 5'd1, S_IDLE = 5'd2, S_NEXT = 5'd3,
    S_RD = 5'd4, S_WAIT = 5'd5, S_MUL = 5'd6, S_MULN = 5'd7, S_PROD = 5'd8,
    S_INV = 5'd9, S_EUC = 5'd10, S_EDIV = 5'd11, S_ESTEP = 5'd12, S_EFIN = 5'd13,
    S_OUT = 5'd14, S_LAST = 5'd15, S_DONE = 5'd16, S_RQ = 5'd17, S_RR = 5'd18,
    S_RC = 5'd19;

  localparam logic [1:0] OP_N = 2'd0, OP_K = 2'd1, OP_D = 2'd2;

  logic [4:0] state, ret;
  logic [TW-1:0] table_mem [PRIME];
  logic [TW-1:0] rd_addr, rd_data;
  logic [TW-1:0] fill_i;
  logic [TW-1:0] fill_acc;
  logic [1:0] which;
  logic [RW-1:0] cur, karg, darg;
  logic odd;
  logic [32:0] e1, e23;
  logic [TW-1:0] res, a1, a2, term;
  // shared reduction by the prime
  logic [RW-1:0] red_x, red_q;
  logic [2*RW-1:0] red_prod;
  logic [TW+1:0] red_rr;
  logic [TW-1:0] red_r;
  // euclid
  logic [TW:0] old_r, r;
  logic signed [TW+1:0] old_s, s, s_fix;
  logic [TW:0] eq;
  logic [TW:0] erem;
  logic [TW+1:0] eshift, ediff;
  logic [EBW-1:0] ebit;
  logic [TW-1:0] inv;
  logic [TW-1:0] fin;
  logic [RES_W-1:0] out_reg;
  logic out_full, out_free, out_load;

  // factorial table memory, registered read
  always_ff @(posedge clk) begin
    if (state == S_FILL) table_mem[fill_i] <= fill_acc;
    rd_data <= table_mem[rd_addr];
  end

  assign item_take = (state == S_IDLE) & item_valid;
  assign empty = ~out_full;
  assign binom_residue = out_reg;
  assign out_free = ~out_full | pop;
  assign out_load = (state == S_DONE) & out_free;

  // datapath helpers
  assign red_prod = (2*RW)'(red_x) * (2*RW)'(BAR_M);
  assign term = (odd && rd_data != '0) ? TW'(PRIME) - rd_data : rd_data;
  assign eshift = {erem, old_r[ebit]};
  assign ediff = eshift - {1'b0, r};
  assign s_fix = old_s[TW+1] ? old_s + PS : old_s;

  // output register, parts the result from the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_reg <= RES_W'(fin);
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill_i <= '0;
      fill_acc <= ONE;
    end else begin
      case (state)
        // sweep the factorial table
        S_FILL: begin
          if (fill_i == TW'(PRIME-1)) begin
            state <= S_IDLE;
          end else begin
            red_x <= RW'(fill_acc) * (RW'(fill_i) + RW'(1));
            ret <= S_FILLN;
            state <= S_RQ;
          end
        end
        S_FILLN: begin
          fill_acc <= red_r;
          fill_i <= fill_i + 1'b1;
          state <= S_FILL;
        end
        S_IDLE: if (item_take) begin
          if (item.zero) begin
            fin <= '0;
            state <= S_DONE;
          end else begin
            which <= OP_N;
            cur <= item.n;
            karg <= item.k;
            darg <= item.d;
            res <= ONE;
            e1 <= '0;
            e23 <= '0;
            state <= S_NEXT;
          end
        end
        // start a digit, move to the next operand, or after the last operand start the product
        S_NEXT: begin
          if (cur == '0) begin
            if (which == OP_N) begin
              a1 <= res; res <= ONE; cur <= karg; which <= OP_K;
            end else if (which == OP_K) begin
              a2 <= res; res <= ONE; cur <= darg; which <= OP_D;
            end else begin
              red_x <= RW'(a2) * RW'(res);
              ret <= S_PROD;
              state <= S_RQ;
            end
          end else begin
            red_x <= cur;
            ret <= S_RD;
            state <= S_RQ;
          end
        end
        // quotient and digit ready, fetch the digit factorial
        S_RD: begin
          rd_addr <= red_r;
          odd <= red_q[0];
          cur <= red_q;
          if (which == OP_N) e1 <= e1 + 33'(red_q); else e23 <= e23 + 33'(red_q);
          state <= S_WAIT;
        end
        S_WAIT: state <= S_MUL;
        S_MUL: begin
          red_x <= RW'(res) * RW'(term);
          ret <= S_MULN;
          state <= S_RQ;
        end
        S_MULN: begin
          res <= red_r;
          state <= S_NEXT;
        end
        S_PROD: begin
          if (e1 > e23) begin
            fin <= '0;
            state <= S_DONE;
          end else begin
            a2 <= red_r;
            state <= S_INV;
          end
        end
        // set up extended euclid
        S_INV: begin
          old_r <= {1'b0, a2};
          r <= (TW+1)'(PRIME);
          old_s <= (TW+2)'(1);
          s <= '0;
          state <= S_EUC;
        end
        S_EUC: begin
          if (r == '0) begin
            state <= S_EFIN;
          end else begin
            eq <= '0;
            erem <= '0;
            ebit <= EBW'(TW);
            state <= S_EDIV;
          end
        end
        // divide old_r by r, one quotient bit per cycle
        S_EDIV: begin
          if (eshift >= {1'b0, r}) begin
            erem <= ediff[TW:0];
            eq[ebit] <= 1'b1;
          end else begin
            erem <= eshift[TW:0];
            eq[ebit] <= 1'b0;
          end
          if (ebit == '0) state <= S_ESTEP;
          else ebit <= ebit - 1'b1;
        end
        S_ESTEP: begin
          old_r <= r;
          r <= erem;
          old_s <= s;
          s <= old_s - $signed({1'b0, eq}) * s;
          state <= S_EUC;
        end
        // bring the coefficient into 0..PRIME-1
        S_EFIN: begin
          inv <= (s_fix >= PS) ? TW'(s_fix - PS) : TW'(s_fix);
          state <= S_OUT;
        end
        S_OUT: begin
          red_x <= RW'(a1) * RW'(inv);
          ret <= S_LAST;
          state <= S_RQ;
        end
        S_LAST: begin
          fin <= red_r;
          state <= S_DONE;
        end
        // hand the result over once the output register is free
        S_DONE: if (out_free) state <= S_IDLE;
        // reduction: reciprocal estimate, remainder, one correction
        S_RQ: begin
          red_q <= RW'(red_prod >> S2);
          state <= S_RR;
        end
        S_RR: begin
          red_rr <= (TW+2)'(red_x - red_q * RW'(PRIME));
          state <= S_RC;
        end
        S_RC: begin
          if (red_rr >= (TW+2)'(PRIME)) begin
            red_q <= red_q + 1'b1;
            red_r <= TW'(red_rr - (TW+2)'(PRIME));
          end else begin
            red_r <= TW'(red_rr);
          end
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    item_take |-> state == S_IDLE) else $error("take outside idle");
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_reg < RES_W'(PRIME)) else $error("residue out of range");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_full || pop) else $error("load into full output");
endmodule

/* sv/binomial_mod_small_prime_unit.sv */
`timescale 1ns / 1ps
// C(n,k) mod PRIME for signed 32-bit n and k; zero for negative arguments or
// k > n. After reset the factorial table is swept in, with no item taken from
// the queue. An item with invalid arguments then gives zero directly;
// otherwise the unit walks the base-PRIME digits of n, k and n-k (each with a
// reciprocal-multiply reduction by the prime), then takes extended Euclid
// steps for the inverse. One item is worked at a time, with a four-entry
// queue in front and an output register that lets the next item start while
// a result waits.
module binomial_mod_small_prime_unit #(
  parameter int PRIME = bmsp_pkg::PRIME_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic signed [31:0] n_value,
  input  logic signed [31:0] k_value,
  input  logic push,
  output logic full,
  output logic [13:0] binom_residue,
  output logic empty,
  input  logic pop
);
  import bmsp_pkg::*;
  bmsp_item_t item;
  logic item_valid, item_take;

  // front: classify and queue
  bmsp_front u_front (
    .clk, .rst, .n_value, .k_value, .push, .full,
    .item, .item_valid, .item_take
  );

  // back: digit walks and inverse
  bmsp_back #(.PRIME(PRIME)) u_back (
    .clk, .rst, .item, .item_valid, .item_take,
    .binom_residue, .empty, .pop
  );
endmodule
